>>> design/sgfg_pkg.sv
package sgfg_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int RING_COLS   = 2 * MATRIX_SIZE;
    localparam int CELL_BITS   = MATRIX_SIZE * MATRIX_SIZE;
    localparam int STEP_W      = $clog2(MATRIX_SIZE);
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    typedef logic [CELL_BITS-1:0] t_cells;
    typedef logic [RING_COLS-1:0] t_ring_row;
    typedef logic [STEP_W-1:0]    t_step;
    typedef logic [1:0]           t_turns;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCROLL_DIRECTION  = 8'd0,
        REG_GLYPH_ORIENTATION = 8'd1
    } t_reg_index;

    typedef struct packed {
        logic   load;
        t_cells cells;
    } t_glyph_load;

    typedef struct packed {
        logic free;
    } t_emit_status;

    // One clockwise quarter turn: new[i][j] = old[7-j][i].
    function automatic t_cells rotate_cw(input t_cells m);
        t_cells o;
        o = '0;
        for (int i = 0; i < MATRIX_SIZE; i++) begin
            for (int j = 0; j < MATRIX_SIZE; j++) begin
                o[i*MATRIX_SIZE + j] = m[(MATRIX_SIZE-1-j)*MATRIX_SIZE + i];
            end
        end
        return o;
    endfunction

    function automatic t_cells rotate_n(input t_cells m, input t_turns n);
        t_cells o;
        case (n)
            2'd0:    o = m;
            2'd1:    o = rotate_cw(m);
            2'd2:    o = rotate_cw(rotate_cw(m));
            2'd3:    o = rotate_cw(rotate_cw(rotate_cw(m)));
            default: o = m;
        endcase
        return o;
    endfunction

    function automatic t_turns orient_turns(input logic [1:0] orient);
        t_turns t;
        case (orient)
            2'd0:    t = 2'd3;
            2'd1:    t = 2'd0;
            2'd2:    t = 2'd1;
            2'd3:    t = 2'd2;
            default: t = 2'd0;
        endcase
        return t;
    endfunction

    function automatic t_turns dir_turns(input logic [1:0] dir);
        t_turns t;
        case (dir)
            2'd0:    t = 2'd0;
            2'd1:    t = 2'd2;
            2'd2:    t = 2'd3;
            2'd3:    t = 2'd1;
            default: t = 2'd0;
        endcase
        return t;
    endfunction

endpackage

>>> design/sgfg_emitter.sv
module sgfg_emitter import sgfg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_glyph_load  i_glyph,
    input  logic [1:0]   i_scroll_direction,
    output t_emit_status o_status,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [63:0]  o_frame_bits,
    output logic [2:0]   o_scroll_step,
    output logic         o_last_frame
);

    localparam t_step LAST_STEP = t_step'(MATRIX_SIZE - 1);

    t_ring_row r_ring [MATRIX_SIZE];
    logic      r_busy;
    logic      r_half;
    t_step     r_step;
    logic      r_out_valid;
    t_cells    r_frame;
    t_step     r_out_step;
    logic      r_out_last;

    logic      can_adv;
    logic      finishing;
    logic      ld_half;
    logic [3:0] start;
    t_cells    window;
    t_cells    n_frame;

    assign can_adv   = !r_out_valid || !i_out_stall;
    assign finishing = r_busy && (r_step == LAST_STEP) && can_adv;
    assign o_status.free = !r_busy || finishing;
    assign ld_half   = r_busy ? ~r_half : r_half;
    assign start     = {r_half, r_step};

    always_comb begin
        logic [2*RING_COLS-1:0] doubled;
        logic [2*RING_COLS-1:0] shifted;
        window = '0;
        for (int r = 0; r < MATRIX_SIZE; r++) begin
            doubled = {r_ring[r], r_ring[r]};
            shifted = doubled >> start;
            window[r*MATRIX_SIZE +: MATRIX_SIZE] = shifted[MATRIX_SIZE-1:0];
        end
        n_frame = rotate_n(window, dir_turns(i_scroll_direction));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MATRIX_SIZE; r++) begin
                r_ring[r] <= '0;
            end
            r_busy      <= 1'b0;
            r_half      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_adv) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_step <= r_step + t_step'(1);
                end
            end
            if (finishing) begin
                r_half <= ~r_half;
                r_busy <= 1'b0;
            end
            if (i_glyph.load) begin
                r_busy <= 1'b1;
                r_step <= '0;
                for (int r = 0; r < MATRIX_SIZE; r++) begin
                    if (ld_half) begin
                        r_ring[r][MATRIX_SIZE-1:0] <=
                            i_glyph.cells[r*MATRIX_SIZE +: MATRIX_SIZE];
                    end else begin
                        r_ring[r][RING_COLS-1:MATRIX_SIZE] <=
                            i_glyph.cells[r*MATRIX_SIZE +: MATRIX_SIZE];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_adv && r_busy) begin
            r_frame    <= n_frame;
            r_out_step <= r_step;
            r_out_last <= (r_step == LAST_STEP);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_bits  = r_frame;
    assign o_scroll_step = r_out_step;
    assign o_last_frame  = r_out_last;

endmodule

>>> design/scrolling_glyph_frame_generator.sv
// Channel   Direction  Handshake              Payload
// input     in         i_in_valid/o_in_stall  i_glyph_rows
// output    out        o_out_valid/i_out_stall o_frame_bits, o_scroll_step, o_last_frame
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each glyph yields eight frames, one per cycle while i_out_stall is low, as the
// output register issues one window per cycle unless the output is stalled.
// A glyph held in the input register loads into the ring as the last frame of
// the previous glyph is issued, so frames of consecutive glyphs follow with no gap.
// Reset is synchronous and clears the ring to blank and the window start to zero.
// An output stall freezes frame generation; the input register still takes one transfer.
module scrolling_glyph_frame_generator import sgfg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [63:0]           i_glyph_rows,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [63:0]           o_frame_bits,
    output logic [2:0]            o_scroll_step,
    output logic                  o_last_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]   r_dir;
    logic [1:0]   r_orient;
    logic         r_in_valid;
    t_cells       r_glyph;
    t_cells       unpacked;
    t_glyph_load  glyph_load;
    t_emit_status status;
    logic         in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && !status.free;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        unpacked = '0;
        for (int k = 0; k < MATRIX_SIZE; k++) begin
            for (int t = 0; t < MATRIX_SIZE; t++) begin
                unpacked[k*MATRIX_SIZE + t] = i_glyph_rows[k*MATRIX_SIZE + (MATRIX_SIZE-1-t)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= '0;
            r_orient   <= '0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SCROLL_DIRECTION:  r_dir    <= i_cfg_data[1:0];
                    REG_GLYPH_ORIENTATION: r_orient <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (glyph_load.load) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_glyph <= rotate_n(unpacked, orient_turns(r_orient));
        end
    end

    assign glyph_load.load  = r_in_valid && status.free;
    assign glyph_load.cells = r_glyph;

    sgfg_emitter u_emitter (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_glyph            (glyph_load),
        .i_scroll_direction (r_dir),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame_bits       (o_frame_bits),
        .o_scroll_step      (o_scroll_step),
        .o_last_frame       (o_last_frame)
    );

endmodule

>>> tb/sv/scrolling_glyph_frame_generator_test.sv
`timescale 1ns / 1ps

module scrolling_glyph_frame_generator_test;
    import sgfg_pkg::*;

    localparam logic [1:0] DIR_RIGHT_TO_LEFT = 2'd0;
    localparam logic [1:0] DIR_LEFT_TO_RIGHT = 2'd1;
    localparam logic [1:0] DIR_TOP_TO_BOTTOM = 2'd2;
    localparam logic [1:0] DIR_BOTTOM_TO_TOP = 2'd3;

    localparam logic [1:0] ORIENT_TOP    = 2'd0;
    localparam logic [1:0] ORIENT_RIGHT  = 2'd1;
    localparam logic [1:0] ORIENT_BOTTOM = 2'd2;
    localparam logic [1:0] ORIENT_LEFT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP    = 8'hFF;

    localparam int SETTLE_CYCLES   = 16;
    localparam int PRINT_LIMIT     = 40;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 20;

    typedef struct {
        logic [63:0] frame;
        logic [2:0]  step;
        logic        last;
    } t_frame_expect;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [63:0]           i_glyph_rows;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [63:0]           o_frame_bits;
    logic [2:0]            o_scroll_step;
    logic                  o_last_frame;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_frame_expect expected_frames[$];
    int            mismatch_count = 0;
    int            stall_style = 0;
    int            stall_hold = 0;

    logic [15:0] ring_rows[MATRIX_SIZE];
    logic [3:0]  view_start = '0;
    logic [1:0]  dir_reg = DIR_RIGHT_TO_LEFT;
    logic [1:0]  orient_reg = ORIENT_TOP;

    scrolling_glyph_frame_generator u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("scrolling_glyph_frame_generator verification failed");
        $finish;
    end

    function automatic t_turns scroll_turns(input logic [1:0] dir);
        case (dir)
            DIR_RIGHT_TO_LEFT: return 2'd0;
            DIR_LEFT_TO_RIGHT: return 2'd2;
            DIR_TOP_TO_BOTTOM: return 2'd3;
            default:           return 2'd1;
        endcase
    endfunction

    function automatic t_turns glyph_turns(input logic [1:0] orient);
        case (orient)
            ORIENT_TOP:    return 2'd3;
            ORIENT_RIGHT:  return 2'd0;
            ORIENT_BOTTOM: return 2'd1;
            default:       return 2'd2;
        endcase
    endfunction

    // Each clockwise turn takes cell [r][c] from [7-c][r] of the previous matrix,
    // so the source of a cell is found by walking that mapping n times.
    function automatic t_cells turn_cells(input t_cells m, input t_turns n);
        t_cells o;
        int     sr;
        int     sc;
        int     held;
        for (int r = 0; r < MATRIX_SIZE; r++) begin
            for (int c = 0; c < MATRIX_SIZE; c++) begin
                sr = r;
                sc = c;
                repeat (n) begin
                    held = sr;
                    sr = MATRIX_SIZE - 1 - sc;
                    sc = held;
                end
                o[r*MATRIX_SIZE + c] = m[sr*MATRIX_SIZE + sc];
            end
        end
        return o;
    endfunction

    task automatic predict_glyph_frames(input logic [63:0] rows);
        t_cells        glyph;
        t_cells        window;
        int            base;
        logic [3:0]    col;
        t_frame_expect want;
        for (int k = 0; k < MATRIX_SIZE; k++) begin
            for (int t = 0; t < MATRIX_SIZE; t++) begin
                glyph[k*MATRIX_SIZE + t] = rows[k*MATRIX_SIZE + 7 - t];
            end
        end
        glyph = turn_cells(glyph, glyph_turns(orient_reg));
        base = (view_start < MATRIX_SIZE) ? MATRIX_SIZE : 0;
        for (int r = 0; r < MATRIX_SIZE; r++) begin
            for (int t = 0; t < MATRIX_SIZE; t++) begin
                ring_rows[r][base + t] = glyph[r*MATRIX_SIZE + t];
            end
        end
        for (int i = 0; i < MATRIX_SIZE; i++) begin
            for (int r = 0; r < MATRIX_SIZE; r++) begin
                for (int t = 0; t < MATRIX_SIZE; t++) begin
                    col = 4'(view_start + i + t);
                    window[r*MATRIX_SIZE + t] = ring_rows[r][col];
                end
            end
            want.frame = turn_cells(window, scroll_turns(dir_reg));
            want.step = 3'(i);
            want.last = (i == MATRIX_SIZE - 1);
            expected_frames.push_back(want);
        end
        view_start = view_start + 4'(MATRIX_SIZE);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_expect want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                report_mismatch($sformatf("frame %h with no frame expected", o_frame_bits));
            end else begin
                want = expected_frames.pop_front();
                if (o_frame_bits !== want.frame) begin
                    report_mismatch($sformatf("step %0d frame_bits %h, expected %h",
                                              want.step, o_frame_bits, want.frame));
                end
                if (o_scroll_step !== want.step) begin
                    report_mismatch($sformatf("scroll_step %0d, expected %0d",
                                              o_scroll_step, want.step));
                end
                if (o_last_frame !== want.last) begin
                    report_mismatch($sformatf("step %0d last_frame %b, expected %b",
                                              want.step, o_last_frame, want.last));
                end
            end
        end
        if (stall_style == 0) begin
            i_out_stall <= 1'b0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_hold <= $urandom_range(0, (stall_style == 2) ? 7 : 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Returns at the edge of the transfer with valid still high, so that a
    // following glyph can go out on the next cycle.
    task automatic send_glyph(input logic [63:0] rows);
        i_in_valid <= 1'b1;
        i_glyph_rows <= rows;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_glyph_frames(rows);
    endtask

    task automatic settle_frames();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (index == REG_SCROLL_DIRECTION) begin
            dir_reg = data[1:0];
        end else if (index == REG_GLYPH_ORIENTATION) begin
            orient_reg = data[1:0];
        end
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_glyph();
        logic [63:0] g;
        case ($urandom_range(0, 4))
            0:       g = {$urandom(), $urandom()};
            1:       g = 64'd1 << $urandom_range(0, 63);
            2:       g = ~(64'd1 << $urandom_range(0, 63));
            3:       g = {8{8'($urandom())}};
            default: g = {$urandom(), $urandom()} & {$urandom(), $urandom()};
        endcase
        return g;
    endfunction

    task automatic test_blank_and_extremes();
        send_glyph(64'h0);
        send_glyph(64'hFFFF_FFFF_FFFF_FFFF);
        send_glyph(64'h0000_0000_0000_0001);
        send_glyph(64'h8000_0000_0000_0000);
        send_glyph(64'hAAAA_AAAA_AAAA_AAAA);
        send_glyph(64'h0123_4567_89AB_CDEF);
        settle_frames();
    endtask

    task automatic test_orientations();
        logic [1:0] orient;
        write_register(REG_SCROLL_DIRECTION, 8'(DIR_RIGHT_TO_LEFT));
        for (int k = 0; k < 4; k++) begin
            orient = 2'(k);
            write_register(REG_GLYPH_ORIENTATION, 8'(orient));
            send_glyph(64'h80C0_E0F0_0102_0408);
            send_glyph(random_glyph());
            settle_frames();
        end
    endtask

    task automatic test_directions();
        logic [1:0] dir;
        write_register(REG_GLYPH_ORIENTATION, 8'(ORIENT_TOP));
        for (int k = 0; k < 4; k++) begin
            dir = 2'(k);
            write_register(REG_SCROLL_DIRECTION, 8'(dir));
            send_glyph(64'hF000_0000_0000_0307);
            settle_frames();
        end
    endtask

    // Only the low two bits of a register survive a write, and writes to
    // indexes past the two registers must leave both untouched.
    task automatic test_register_masking();
        write_register(REG_SCROLL_DIRECTION, 8'hFD);
        write_register(REG_GLYPH_ORIENTATION, 8'hFE);
        write_register(REG_INDEX_UNUSED, 8'h03);
        write_register(REG_INDEX_TOP, 8'hFF);
        send_glyph(64'h1824_4281_FF81_8181);
        send_glyph(random_glyph());
        settle_frames();
    endtask

    task automatic test_random_scroll();
        int sent;
        int burst;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                write_register(REG_SCROLL_DIRECTION, 8'(DIR_RIGHT_TO_LEFT));
                write_register(REG_GLYPH_ORIENTATION, 8'(ORIENT_TOP));
            end else if (phase == 1) begin
                write_register(REG_SCROLL_DIRECTION, 8'(DIR_BOTTOM_TO_TOP));
                write_register(REG_GLYPH_ORIENTATION, 8'(ORIENT_LEFT));
            end else begin
                write_register(REG_SCROLL_DIRECTION, 8'($urandom()));
                write_register(REG_GLYPH_ORIENTATION, 8'($urandom()));
                if ($urandom_range(0, 2) == 0) begin
                    write_register(8'($urandom_range(REG_INDEX_UNUSED, REG_INDEX_TOP)),
                                   8'($urandom()));
                end
            end
            stall_style = phase % 3;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 12);
                while (burst != 0 && sent < ITEMS_PER_PHASE) begin
                    send_glyph(random_glyph());
                    sent++;
                    burst--;
                end
                if (phase == 5 && sent >= ITEMS_PER_PHASE / 2 && sent < ITEMS_PER_PHASE) begin
                    settle_frames();
                end else if (phase != 3 && sent < ITEMS_PER_PHASE) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
            settle_frames();
        end
        stall_style = 0;
    endtask

    initial begin
        for (int r = 0; r < MATRIX_SIZE; r++) begin
            ring_rows[r] = '0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_glyph_rows <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_SCROLL_DIRECTION;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_blank_and_extremes();
        test_orientations();
        test_directions();
        test_register_masking();
        test_random_scroll();

        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("scrolling_glyph_frame_generator verification clean");
        end else begin
            $display("scrolling_glyph_frame_generator verification failed");
        end
        $finish;
    end

endmodule
